### design/dq_pkg.sv
// Shared types and constants for the double-ended queue core.
// No dependencies; used by dq_ptr, double_ended_queue_core and both bench files.
`default_nettype none

package dq_pkg;

  // width of the value fields on the ports
  localparam int unsigned PORT_VALUE_W = 32;

  // command codes; code 7 is a no-op
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_VALUE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // memory request and result status for one command
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    status_e status;
  } dq_req_t;

endpackage

`default_nettype wire

### design/dq_ram.sv
// Single-port synchronous slot memory with registered read data.
// Depends on nothing; instantiated by double_ended_queue_core.
`default_nettype none

module dq_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/dq_ptr.sv
// Front pointer and item count of the ring buffer; decodes a command
// into at most one memory access and a status. Uses dq_pkg.
`default_nettype none

module dq_ptr #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [2:0]       cmd_i,
  output dq_pkg::dq_req_t       req_o,
  output logic      [IDX_W-1:0] addr_o,
  output logic      [CNT_W-1:0] count_o
);

  localparam int unsigned SUM_W = IDX_W + 1;

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic             full;
  logic             empty;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [IDX_W-1:0] cnt_lo;
  logic [SUM_W-1:0] tail_sum;
  logic [SUM_W-1:0] back_sum;
  logic [IDX_W-1:0] tail_slot;
  logic [IDX_W-1:0] back_slot;
  dq_pkg::dq_req_t  req;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // wrapping neighbors of the front slot
  assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;

  // slot past the back (push back) and the back slot (pop or peek back)
  assign cnt_lo    = count_q[IDX_W-1:0];
  assign tail_sum  = {1'b0, front_q} + {1'b0, cnt_lo};
  assign back_sum  = {1'b0, front_q} + {1'b0, IDX_W'(cnt_lo - 1'b1)};
  assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : tail_sum[IDX_W-1:0];
  assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                  : back_sum[IDX_W-1:0];

  // command decode
  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    addr_o     = front_q;
    req.wr_en  = 1'b0;
    req.rd_en  = 1'b0;
    req.status = dq_pkg::ST_OK;
    case (dq_pkg::cmd_e'(cmd_i))
      dq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          req.status = dq_pkg::ST_FULL;
        end else begin
          front_d   = front_dec;
          addr_o    = front_dec;
          req.wr_en = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      dq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          req.status = dq_pkg::ST_FULL;
        end else begin
          addr_o    = tail_slot;
          req.wr_en = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      dq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          req.status = dq_pkg::ST_EMPTY;
        end else begin
          req.rd_en  = 1'b1;
          req.status = dq_pkg::ST_VALUE;
          front_d    = front_inc;
          count_d    = count_q - 1'b1;
        end
      end
      dq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          req.status = dq_pkg::ST_EMPTY;
        end else begin
          addr_o     = back_slot;
          req.rd_en  = 1'b1;
          req.status = dq_pkg::ST_VALUE;
          count_d    = count_q - 1'b1;
        end
      end
      dq_pkg::CMD_PEEK_FRONT: begin
        if (empty) begin
          req.status = dq_pkg::ST_EMPTY;
        end else begin
          req.rd_en  = 1'b1;
          req.status = dq_pkg::ST_VALUE;
        end
      end
      dq_pkg::CMD_PEEK_BACK: begin
        if (empty) begin
          req.status = dq_pkg::ST_EMPTY;
        end else begin
          addr_o     = back_slot;
          req.rd_en  = 1'b1;
          req.status = dq_pkg::ST_VALUE;
        end
      end
      dq_pkg::CMD_CLEAR: begin
        front_d = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // memory enables only fire on a transfer
  always_comb begin
    req_o       = req;
    req_o.wr_en = req.wr_en & accept_i;
    req_o.rd_en = req.rd_en & accept_i;
  end

  // pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

### design/double_ended_queue_core.sv
// Top level of the bounded double-ended queue core.
// Uses dq_pkg, dq_ptr and dq_ram.
// A bounded double-ended queue of DEPTH tokens of VALUE_BITS bits, kept as a ring buffer in
// one single-port synchronous memory. Every command (push or pop at either end, peek at
// either end, clear, no-op) produces exactly one result. The memory access is issued at the
// input transfer edge, the read stage holds the command, and the output register loads the
// result once it is empty or its result is taken, so a stalled output can hold it back.
// One command per cycle is sustained, set by the single memory port that each command uses
// at most once; the input stalls only while the read stage holds a result that cannot move
// into a full, stalled output register. Pointer updates take effect at the input transfer,
// so a pop right after a push sees the new slot.
// Push values are kept to their low VALUE_BITS bits; results carry the low 32 bits.
`default_nettype none

module double_ended_queue_core #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [31:0] push_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [1:0]  status_o,
  output logic      [31:0] result_value_o
);

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned PW     = dq_pkg::PORT_VALUE_W;
  localparam int unsigned EXT_W  = VALUE_BITS + PW;

  logic                  accept;
  logic                  advance;
  dq_pkg::dq_req_t       req;
  logic [IDX_W-1:0]      addr;
  logic [CNT_W-1:0]      count;
  logic [EXT_W-1:0]      wdata_ext;
  logic [EXT_W-1:0]      rdata_ext;
  logic [VALUE_BITS-1:0] rdata;

  logic            pend_q, pend_d;
  dq_pkg::dq_req_t pend_req_q;
  logic            out_valid_q, out_valid_d;
  dq_pkg::status_e out_status_q;
  logic [PW-1:0]   out_value_q;

  // handshake
  assign advance    = pend_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pend_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  dq_ptr #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ptr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .req_o    (req),
    .addr_o   (addr),
    .count_o  (count)
  );

  // resize values between port and memory width
  assign wdata_ext = {VALUE_BITS'(0), push_value_i};
  assign rdata_ext = {PW'(0), rdata};

  dq_ram #(
    .DEPTH  (DEPTH),
    .WIDTH  (VALUE_BITS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req.wr_en),
    .re_i    (req.rd_en),
    .addr_i  (addr),
    .wdata_i (wdata_ext[VALUE_BITS-1:0]),
    .rdata_o (rdata)
  );

  // read stage occupancy
  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (advance) begin
      pend_d = 1'b0;
    end
  end

  // output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_req_q <= req;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q <= pend_req_q.status;
      out_value_q  <= (pend_req_q.status == dq_pkg::ST_VALUE) ? rdata_ext[PW-1:0] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_value_o = out_value_q;

`ifndef SYNTH
  // item count stays within the ring
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(DEPTH))
    else $error("item count exceeds depth");

  // a transfer always lands in the read stage
  a_accept_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q)
    else $error("accepted command lost");

  // pop or peek on an empty queue reports empty
  a_empty_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && count == '0 &&
     (cmd_i == 3'(dq_pkg::CMD_POP_FRONT) || cmd_i == 3'(dq_pkg::CMD_POP_BACK) ||
      cmd_i == 3'(dq_pkg::CMD_PEEK_FRONT) || cmd_i == 3'(dq_pkg::CMD_PEEK_BACK)))
    |=> pend_req_q.status == dq_pkg::ST_EMPTY)
    else $error("missing empty error");

  // only returned values are nonzero
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != 2'(dq_pkg::ST_VALUE)) |-> result_value_o == '0)
    else $error("nonzero value without value status");
`endif

endmodule

`default_nettype wire

### bench/dq_checker.sv
// Checker for the double-ended queue core: watches both channels, predicts each reply.
// Depends on dq_pkg for the command and status codes.
module dq_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [31:0] push_value_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [1:0]  status_i,
  input  wire logic [31:0] result_value_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  localparam int unsigned SLOTS = 64;

  typedef struct packed {
    dq_pkg::status_e status;
    logic [31:0]     value;
  } reply_t;

  // shadow copy of the ring buffer
  logic [31:0] ring_slots [SLOTS];
  logic [5:0]  head_idx;
  logic [6:0]  held;

  reply_t reply_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    head_idx     = '0;
    held         = '0;
  end

  // apply one command to the shadow queue and return the reply it should give
  function automatic reply_t apply_command(input logic [2:0] op, input logic [31:0] val);
    reply_t     rep;
    logic [5:0] idx;
    rep.status = dq_pkg::ST_OK;
    rep.value  = '0;
    case (op)
      dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
        if (held >= 7'(SLOTS)) begin
          rep.status = dq_pkg::ST_FULL;
        end else if (op == dq_pkg::CMD_PUSH_FRONT) begin
          head_idx = head_idx - 6'd1;
          ring_slots[head_idx] = val;
          held = held + 7'd1;
        end else begin
          idx = head_idx + held[5:0];
          ring_slots[idx] = val;
          held = held + 7'd1;
        end
      end
      dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK,
      dq_pkg::CMD_PEEK_FRONT, dq_pkg::CMD_PEEK_BACK: begin
        if (held == 7'd0) begin
          rep.status = dq_pkg::ST_EMPTY;
        end else begin
          if (op == dq_pkg::CMD_POP_FRONT || op == dq_pkg::CMD_PEEK_FRONT) idx = head_idx;
          else idx = head_idx + 6'(held - 7'd1);
          rep.value  = ring_slots[idx];
          rep.status = dq_pkg::ST_VALUE;
          if (op == dq_pkg::CMD_POP_FRONT) begin
            head_idx = head_idx + 6'd1;
            held = held - 7'd1;
          end else if (op == dq_pkg::CMD_POP_BACK) begin
            held = held - 7'd1;
          end
        end
      end
      dq_pkg::CMD_CLEAR: begin
        head_idx = '0;
        held     = '0;
      end
      default: begin
      end
    endcase
    return rep;
  endfunction

  // compare reply transfers first, then predict the command transfer of this edge
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          $error("reply transfer with nothing expected: status %0d value %h",
                 status_i, result_value_i);
          fail_count_o++;
        end else begin
          want = reply_q.pop_front();
          checked_o++;
          if (status_i !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_i);
            fail_count_o++;
          end
          if (result_value_i !== want.value) begin
            $error("result_value mismatch: expected %h, actual %h",
                   want.value, result_value_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        reply_q.push_back(apply_command(cmd_i, push_value_i));
      end
      pending_o = reply_q.size();
    end
  end

endmodule

### bench/double_ended_queue_core_test.sv
// Top of the double-ended queue core bench: clock, reset, command stimulus and verdict.
// Depends on dq_pkg, double_ended_queue_core and dq_checker.
module double_ended_queue_core_test;

  localparam logic [2:0] CMD_NOP     = 3'd7;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         RANDOM_CMDS = 400;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [2:0]  cmd          = CMD_NOP;
  logic [31:0] push_value   = '0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  status;
  logic [31:0] result_value;

  int fail_count;
  int pending;
  int checked;
  int cycles = 0;
  int sent   = 0;
  int fills  = 0;
  int drains = 0;
  bit steady = 1'b0;

  double_ended_queue_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .push_value_i   (push_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .result_value_o (result_value)
  );

  dq_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .cmd_i          (cmd),
    .push_value_i   (push_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .result_value_i (result_value),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("double_ended_queue_core regression: fail");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // reply side stall pattern
  initial begin
    int len;
    forever begin
      len = $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (len) @(posedge clk);
      len = pick_gap();
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
    end
  end

  // one command transfer, preceded by a random idle gap
  task automatic issue(input logic [2:0] op, input logic [31:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid   <= 1'b0;
      cmd        <= 3'($urandom);
      push_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    push_value <= val;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic logic [2:0] any_push();
    return $urandom_range(0, 1) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK;
  endfunction

  function automatic logic [2:0] any_read(input bit pops_only);
    int r;
    r = $urandom_range(0, pops_only ? 1 : 3);
    case (r)
      0: return dq_pkg::CMD_POP_FRONT;
      1: return dq_pkg::CMD_POP_BACK;
      2: return dq_pkg::CMD_PEEK_FRONT;
      default: return dq_pkg::CMD_PEEK_BACK;
    endcase
  endfunction

  initial begin
    int kind;
    int r;
    int stop_at;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty errors, value extremes, both ends, no-op, clear
    issue(dq_pkg::CMD_POP_FRONT, 32'hFFFF_FFFF);
    issue(dq_pkg::CMD_POP_BACK, '0);
    issue(dq_pkg::CMD_PEEK_FRONT, '0);
    issue(dq_pkg::CMD_PEEK_BACK, '0);
    issue(dq_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
    issue(dq_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF);
    issue(dq_pkg::CMD_PEEK_FRONT, '0);
    issue(dq_pkg::CMD_PEEK_BACK, '0);
    issue(dq_pkg::CMD_PUSH_FRONT, 32'h8000_0001);
    issue(dq_pkg::CMD_POP_BACK, '0);
    issue(dq_pkg::CMD_POP_FRONT, '0);
    issue(dq_pkg::CMD_POP_FRONT, '0);
    issue(dq_pkg::CMD_POP_FRONT, '0);
    issue(CMD_NOP, 32'hFFFF_FFFF);
    issue(dq_pkg::CMD_PUSH_BACK, 32'hA5A5_A5A5);
    issue(dq_pkg::CMD_PUSH_BACK, 32'h5A5A_5A5A);
    issue(dq_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
    issue(dq_pkg::CMD_PEEK_BACK, '0);
    issue(dq_pkg::CMD_POP_BACK, '0);
    issue(dq_pkg::CMD_PUSH_FRONT, 32'h0000_0001);
    issue(dq_pkg::CMD_POP_BACK, '0);
    issue(dq_pkg::CMD_PEEK_FRONT, '0);

    // random episodes with random content
    stop_at = sent + RANDOM_CMDS;
    while (sent < stop_at) begin
      steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        // clear, then push up to full and often past it to hit the full error
        fills++;
        issue(dq_pkg::CMD_CLEAR, $urandom);
        repeat ($urandom_range(64, 68)) issue(any_push(), $urandom);
        issue(any_read(1'b0), $urandom);
      end else if (kind < 30) begin
        // drain with pops and some peeks, often past empty
        drains++;
        repeat ($urandom_range(20, 70)) begin
          if ($urandom_range(0, 4) == 0) issue(any_read(1'b0), $urandom);
          else issue(any_read(1'b1), $urandom);
        end
      end else if (kind < 90) begin
        // mixed traffic, leaning toward pushes
        repeat ($urandom_range(10, 40)) begin
          r = $urandom_range(0, 99);
          if (r < 45) issue(any_push(), $urandom);
          else if (r < 75) issue(any_read(1'b1), $urandom);
          else if (r < 95) issue(any_read(1'b0), $urandom);
          else if (r < 97) issue(dq_pkg::CMD_CLEAR, $urandom);
          else issue(CMD_NOP, $urandom);
        end
      end else begin
        // raw noise over all codes
        repeat ($urandom_range(4, 12)) issue(3'($urandom_range(0, 7)), $urandom);
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain outstanding replies, then allow for pipeline latency
    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);

    $display("sent %0d commands, %0d replies compared", sent, checked);
    $display("included %0d fill-to-full and %0d drain-to-empty episodes", fills, drains);
    if (fail_count == 0) begin
      $display("double_ended_queue_core regression: pass");
    end else begin
      $display("double_ended_queue_core regression: fail");
    end
    $finish;
  end

endmodule

### files.f
design/dq_pkg.sv
design/dq_ram.sv
design/dq_ptr.sv
design/double_ended_queue_core.sv
bench/dq_checker.sv
bench/double_ended_queue_core_test.sv
